>>> hw/rtl/bscu_pkg.sv
// ----------------------------------------------------------------------------
// bscu_pkg
// shared types, constants and helpers of the barometer compensation unit
// ----------------------------------------------------------------------------
package bscu_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [2:0] REG_COEF_A = 3'd0;
   localparam logic [2:0] REG_COEF_U = 3'd1;
   localparam logic [2:0] REG_COEF_B = 3'd2;
   localparam logic [2:0] REG_COEF_M = 3'd3;
   localparam logic [2:0] REG_OSS    = 3'd4;

   localparam logic [1:0] OSS_RESET = 2'd3;

   // compensation constants
   localparam logic [31:0] B6_OFFSET = 32'd4000;
   localparam logic [31:0] B4_BIAS   = 32'd32768;
   localparam logic [31:0] B7_SCALE  = 32'd50000;
   localparam logic [31:0] P_COEF_SQ = 32'd3038;
   localparam logic [31:0] P_COEF_LN = 32'hFFFF_E343;  // -7357
   localparam logic [31:0] P_ROUND   = 32'd3791;
   localparam logic [31:0] T_ROUND   = 32'd8;

   typedef enum logic {
      OP_TEMP = 1'b0,
      OP_PRES = 1'b1
   } op_type;

   typedef struct packed {
      logic        operation;
      logic [18:0] raw_value;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] value;
      logic               div_error;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [18:0] raw;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic [47:0] coef_a;
      logic [47:0] coef_u;
      logic [31:0] coef_b;
      logic [31:0] coef_m;
      logic [1:0]  oss;
   } cfg_type;

   typedef enum logic [4:0] {
      S_IDLE, S_T0, S_T1, S_T2, S_TDIV,
      S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
      S_PDIV, S_P10, S_P11, S_P12, S_P13, S_P14, S_OUT
   } eng_state_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

endpackage

>>> hw/rtl/bscu_front.sv
// ----------------------------------------------------------------------------
// bscu_front
// accepts request transactions, tags them and queues them for the engine
// ----------------------------------------------------------------------------
module bscu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bscu_pkg::req_type req_payload,
   output bscu_pkg::head_type head,
   input  logic              pop
);

   bscu_pkg::item_type entry_ff [2];
   bscu_pkg::item_type entry_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       take;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign take      = pop && (count_ff != 2'd0);

   // classify the raw transaction
   assign entry_in.op  = bscu_pkg::op_type'(req_payload.operation);
   assign entry_in.raw = req_payload.raw_value;

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/bscu_divider.sv
// ----------------------------------------------------------------------------
// bscu_divider
// unsigned 32 by 32 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bscu_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = 5'd0;
         rem_in   = 32'd0;
         quo_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 5'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/bscu_engine.sv
// ----------------------------------------------------------------------------
// bscu_engine
// sequencer with one shared multiplier and the divider, holds b5
// ----------------------------------------------------------------------------
module bscu_engine (
   input  logic               clock,
   input  logic               reset,
   input  bscu_pkg::cfg_type  cfg,
   input  bscu_pkg::head_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bscu_pkg::rsp_type  rsp_payload
);

   bscu_pkg::eng_state_type state_ff, state_in;
   bscu_pkg::item_type      item_ff, item_in;
   bscu_pkg::rsp_type       rsp_payload_ff, rsp_payload_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] temp_ff, temp_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] x1_ff, x1_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] b6_ff, b6_in;
   logic [31:0] sq_ff, sq_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] b3_ff, b3_in;
   logic [31:0] b4_ff, b4_in;
   logic [31:0] b7_ff, b7_in;
   logic [31:0] p_ff, p_in;
   logic [31:0] res_value_ff, res_value_in;
   logic        res_err_ff, res_err_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_full;
   logic        div_start, div_done;
   logic [31:0] div_dividend, div_divisor, div_quotient;

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   logic [31:0] ut, t_num, t_num_abs, den_abs, q_signed, b5, x3;

   assign ac1 = bscu_pkg::sext16(cfg.coef_a[47:32]);
   assign ac2 = bscu_pkg::sext16(cfg.coef_a[31:16]);
   assign ac3 = bscu_pkg::sext16(cfg.coef_a[15:0]);
   assign ac4 = {16'd0, cfg.coef_u[47:32]};
   assign ac5 = {16'd0, cfg.coef_u[31:16]};
   assign ac6 = {16'd0, cfg.coef_u[15:0]};
   assign b1  = bscu_pkg::sext16(cfg.coef_b[31:16]);
   assign b2  = bscu_pkg::sext16(cfg.coef_b[15:0]);
   assign mc  = bscu_pkg::sext16(cfg.coef_m[31:16]);
   assign md  = bscu_pkg::sext16(cfg.coef_m[15:0]);

   assign ut        = {16'd0, item_ff.raw[15:0]};
   assign t_num     = {mc[20:0], 11'd0};
   assign t_num_abs = t_num[31] ? (32'd0 - t_num) : t_num;
   assign den_abs   = den_ff[31] ? (32'd0 - den_ff) : den_ff;
   assign q_signed  = (t_num[31] ^ den_ff[31]) ? (32'd0 - div_quotient) : div_quotient;
   assign b5        = x1_ff + q_signed;
   assign x3        = bscu_pkg::asr(prod_ff, 5'd11) + acc_ff;

   // shared multiplier operand select, low 32 bits of the product registered
   always_comb begin
      unique case (state_ff)
         bscu_pkg::S_T0: begin
            mul_a = ut - ac6;
            mul_b = ac5;
         end
         bscu_pkg::S_P1: begin
            mul_a = b6_ff;
            mul_b = b6_ff;
         end
         bscu_pkg::S_P2: begin
            mul_a = ac2;
            mul_b = b6_ff;
         end
         bscu_pkg::S_P3: begin
            mul_a = b2;
            mul_b = sq_ff;
         end
         bscu_pkg::S_P4: begin
            mul_a = ac3;
            mul_b = b6_ff;
         end
         bscu_pkg::S_P5: begin
            mul_a = b1;
            mul_b = sq_ff;
         end
         bscu_pkg::S_P7: begin
            mul_a = ac4;
            mul_b = acc_ff + bscu_pkg::B4_BIAS;
         end
         bscu_pkg::S_P8: begin
            mul_a = {13'd0, item_ff.raw} - b3_ff;
            mul_b = bscu_pkg::B7_SCALE >> cfg.oss;
         end
         bscu_pkg::S_P10: begin
            mul_a = bscu_pkg::asr(p_ff, 5'd8);
            mul_b = bscu_pkg::asr(p_ff, 5'd8);
         end
         bscu_pkg::S_P11: begin
            mul_a = prod_ff;
            mul_b = bscu_pkg::P_COEF_SQ;
         end
         bscu_pkg::S_P12: begin
            mul_a = bscu_pkg::P_COEF_LN;
            mul_b = p_ff;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign prod_in  = mul_full[31:0];

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      temp_in        = temp_ff;
      x1_in          = x1_ff;
      den_in         = den_ff;
      b6_in          = b6_ff;
      sq_in          = sq_ff;
      acc_in         = acc_ff;
      b3_in          = b3_ff;
      b4_in          = b4_ff;
      b7_in          = b7_ff;
      p_in           = p_ff;
      res_value_in   = res_value_ff;
      res_err_in     = res_err_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      pop            = 1'b0;
      div_start      = 1'b0;
      div_dividend   = t_num_abs;
      div_divisor    = den_abs;
      unique case (state_ff)
         bscu_pkg::S_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               item_in  = head.item;
               state_in = (head.item.op == bscu_pkg::OP_TEMP) ? bscu_pkg::S_T0
                                                             : bscu_pkg::S_P0;
            end
         end
         // temperature
         bscu_pkg::S_T0: state_in = bscu_pkg::S_T1;
         bscu_pkg::S_T1: begin
            x1_in    = bscu_pkg::asr(prod_ff, 5'd15);
            den_in   = bscu_pkg::asr(prod_ff, 5'd15) + md;
            state_in = bscu_pkg::S_T2;
         end
         bscu_pkg::S_T2: begin
            if (den_ff == 32'd0) begin
               res_err_in   = 1'b1;
               res_value_in = 32'd0;
               state_in     = bscu_pkg::S_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = bscu_pkg::S_TDIV;
            end
         end
         bscu_pkg::S_TDIV: begin
            if (div_done) begin
               temp_in      = b5;
               res_value_in = bscu_pkg::asr(b5 + bscu_pkg::T_ROUND, 5'd4);
               res_err_in   = 1'b0;
               state_in     = bscu_pkg::S_OUT;
            end
         end
         // pressure
         bscu_pkg::S_P0: begin
            b6_in    = temp_ff - bscu_pkg::B6_OFFSET;
            state_in = bscu_pkg::S_P1;
         end
         bscu_pkg::S_P1: state_in = bscu_pkg::S_P2;
         bscu_pkg::S_P2: begin
            sq_in    = bscu_pkg::asr(prod_ff, 5'd12);
            state_in = bscu_pkg::S_P3;
         end
         bscu_pkg::S_P3: begin
            acc_in   = bscu_pkg::asr(prod_ff, 5'd11);
            state_in = bscu_pkg::S_P4;
         end
         bscu_pkg::S_P4: begin
            x1_in    = {ac1[29:0], 2'b00} + x3;
            state_in = bscu_pkg::S_P5;
         end
         bscu_pkg::S_P5: begin
            b3_in    = bscu_pkg::asr((x1_ff << cfg.oss) + 32'd2, 5'd2);
            acc_in   = bscu_pkg::asr(prod_ff, 5'd13);
            state_in = bscu_pkg::S_P6;
         end
         bscu_pkg::S_P6: begin
            acc_in   = bscu_pkg::asr(acc_ff + bscu_pkg::asr(prod_ff, 5'd16) + 32'd2, 5'd2);
            state_in = bscu_pkg::S_P7;
         end
         bscu_pkg::S_P7: state_in = bscu_pkg::S_P8;
         bscu_pkg::S_P8: begin
            b4_in    = prod_ff >> 15;
            state_in = bscu_pkg::S_P9;
         end
         bscu_pkg::S_P9: begin
            b7_in = prod_ff;
            if (b4_ff == 32'd0) begin
               res_err_in   = 1'b1;
               res_value_in = 32'd0;
               state_in     = bscu_pkg::S_OUT;
            end else begin
               div_start    = 1'b1;
               div_dividend = prod_ff[31] ? prod_ff : {prod_ff[30:0], 1'b0};
               div_divisor  = b4_ff;
               state_in     = bscu_pkg::S_PDIV;
            end
         end
         bscu_pkg::S_PDIV: begin
            if (div_done) begin
               p_in     = b7_ff[31] ? {div_quotient[30:0], 1'b0} : div_quotient;
               state_in = bscu_pkg::S_P10;
            end
         end
         bscu_pkg::S_P10: state_in = bscu_pkg::S_P11;
         bscu_pkg::S_P11: state_in = bscu_pkg::S_P12;
         bscu_pkg::S_P12: begin
            acc_in   = bscu_pkg::asr(prod_ff, 5'd16);
            state_in = bscu_pkg::S_P13;
         end
         bscu_pkg::S_P13: begin
            acc_in   = acc_ff + bscu_pkg::asr(prod_ff, 5'd16) + bscu_pkg::P_ROUND;
            state_in = bscu_pkg::S_P14;
         end
         bscu_pkg::S_P14: begin
            res_value_in = p_ff + bscu_pkg::asr(acc_ff, 5'd4);
            res_err_in   = 1'b0;
            state_in     = bscu_pkg::S_OUT;
         end
         bscu_pkg::S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.kind      = item_ff.op;
               rsp_payload_in.value     = res_value_ff;
               rsp_payload_in.div_error = res_err_ff;
               state_in                 = bscu_pkg::S_IDLE;
            end
         end
         default: state_in = bscu_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bscu_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         temp_ff      <= 32'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         temp_ff      <= temp_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      prod_ff        <= prod_in;
      x1_ff          <= x1_in;
      den_ff         <= den_in;
      b6_ff          <= b6_in;
      sq_ff          <= sq_in;
      acc_ff         <= acc_in;
      b3_ff          <= b3_in;
      b4_ff          <= b4_in;
      b7_ff          <= b7_in;
      p_ff           <= p_in;
      res_value_ff   <= res_value_in;
      res_err_ff     <= res_err_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   bscu_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.div_error |-> rsp_payload_ff.value == 32'sd0)
      else $error("error result with nonzero value");

   a_zero_den_keeps_b5: assert property (@(posedge clock) disable iff (reset)
      state_ff == bscu_pkg::S_T2 && den_ff == 32'd0 |=> $stable(temp_ff))
      else $error("b5 changed on zero divisor");

   a_div_start_place: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (state_ff == bscu_pkg::S_T2 || state_ff == bscu_pkg::S_P9))
      else $error("divider started outside a launch step");

   a_div_done_place: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == bscu_pkg::S_TDIV || state_ff == bscu_pkg::S_PDIV))
      else $error("divider finished while not awaited");
`endif

endmodule

>>> hw/rtl/baro_sensor_compensation_unit.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation_unit
// integer temperature and pressure compensation for a digital barometer
// ----------------------------------------------------------------------------
// Raw readings come in tagged as temperature (operation 0) or pressure
// (operation 1) and each gives one response transaction. A temperature
// reading computes b5, keeps it and returns degrees in 0.1 degC; a pressure
// reading uses the kept b5 (0 after reset) and the oversampling setting and
// returns pascals. A zero divisor gives div_error with value 0; in the
// temperature case b5 is then left as it was. Each transaction runs
// through steps of the single shared 32x32 multiplier and the restoring
// divider. A two-deep queue in front takes new requests while the engine
// works, and the response register lets the engine start the next one
// while a result waits. The calibration registers sit on a 64-bit
// APB-style port at byte address 8*i; write them only while the unit is
// idle.
module baro_sensor_compensation_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bscu_pkg::req_type                   req_payload,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bscu_pkg::rsp_type                   rsp_payload,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bscu_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bscu_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bscu_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   bscu_pkg::cfg_type  cfg_ff, cfg_in;
   bscu_pkg::head_type head;
   logic               pop;
   logic               csr_write;
   logic [2:0]         csr_index;

   // register index from the 8-byte aligned address
   assign csr_index  = csr_paddr[5:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            bscu_pkg::REG_COEF_A: cfg_in.coef_a = csr_pwdata[47:0];
            bscu_pkg::REG_COEF_U: cfg_in.coef_u = csr_pwdata[47:0];
            bscu_pkg::REG_COEF_B: cfg_in.coef_b = csr_pwdata[31:0];
            bscu_pkg::REG_COEF_M: cfg_in.coef_m = csr_pwdata[31:0];
            bscu_pkg::REG_OSS:    cfg_in.oss    = csr_pwdata[1:0];
            default:              cfg_in        = cfg_ff;  // unmapped, ignored
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_index)
         bscu_pkg::REG_COEF_A: csr_prdata = {16'd0, cfg_ff.coef_a};
         bscu_pkg::REG_COEF_U: csr_prdata = {16'd0, cfg_ff.coef_u};
         bscu_pkg::REG_COEF_B: csr_prdata = {32'd0, cfg_ff.coef_b};
         bscu_pkg::REG_COEF_M: csr_prdata = {32'd0, cfg_ff.coef_m};
         bscu_pkg::REG_OSS:    csr_prdata = {62'd0, cfg_ff.oss};
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_a <= 48'd0;
         cfg_ff.coef_u <= 48'd0;
         cfg_ff.coef_b <= 32'd0;
         cfg_ff.coef_m <= 32'd0;
         cfg_ff.oss    <= bscu_pkg::OSS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept, tag and queue
   bscu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .head        (head),
      .pop         (pop)
   );

   // back: compensation sequencer and response register
   bscu_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> sim/baro_sensor_compensation_unit_tb.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation_unit_tb
// self-checking bench for the barometer compensation unit
// ----------------------------------------------------------------------------
// Drives temperature and pressure readings through the request channel and
// checks every response against a cycle-free integer model of the
// compensation held in the bench. Calibration goes in over the APB-style port
// while the unit is idle. Directed tests cover the reset state, a known
// calibration, zero divisors and extreme coefficients; random phases follow
// with varying calibration, oversampling, sender gaps and receiver stalls.
module baro_sensor_compensation_unit_tb;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   bscu_pkg::req_type               req_payload;
   logic                            rsp_valid;
   logic                            rsp_stall;
   bscu_pkg::rsp_type               rsp_payload;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [bscu_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [bscu_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [bscu_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   baro_sensor_compensation_unit dut (.*);

   // bench copy of the calibration and of the kept b5
   logic [47:0] cal_a;
   logic [47:0] cal_u;
   logic [31:0] cal_b;
   logic [31:0] cal_m;
   logic [1:0]  cal_oss;
   int          held_b5;

   bscu_pkg::rsp_type pending_results[$];
   int                error_count;
   int                idle_pct;
   int                stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous cap on the whole run
   initial begin
      #20_000_000;
      $display("[baro_sensor_compensation_unit] ERROR");
      $finish;
   end

   // compensation of one reading; updates held_b5 like the unit does
   function automatic bscu_pkg::rsp_type compensate(input bscu_pkg::req_type item);
      bscu_pkg::rsp_type res;
      int          ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
      int          ut, x1, x2, x3, den, b6, sq, b3, p, h;
      int unsigned ac4, b4, b7, q, rawu, oss;
      res.kind      = item.operation;
      res.value     = 0;
      res.div_error = 1'b0;
      if (item.operation == bscu_pkg::OP_TEMP) begin
         ac5 = int'({16'd0, cal_u[31:16]});
         ac6 = int'({16'd0, cal_u[15:0]});
         mc  = int'($signed(cal_m[31:16]));
         md  = int'($signed(cal_m[15:0]));
         ut  = int'({16'd0, item.raw_value[15:0]});
         x1  = ((ut - ac6) * ac5) >>> 15;
         den = x1 + md;
         if (den == 0) begin
            // b5 stays as it was
            res.div_error = 1'b1;
         end else begin
            x2 = int'((longint'(mc) * 2048) / longint'(den));
            held_b5 = x1 + x2;
            res.value = (held_b5 + 8) >>> 4;
         end
      end else begin
         ac1  = int'($signed(cal_a[47:32]));
         ac2  = int'($signed(cal_a[31:16]));
         ac3  = int'($signed(cal_a[15:0]));
         ac4  = {16'd0, cal_u[47:32]};
         b1   = int'($signed(cal_b[31:16]));
         b2   = int'($signed(cal_b[15:0]));
         oss  = {30'd0, cal_oss};
         rawu = {13'd0, item.raw_value};
         b6 = held_b5 - 4000;
         sq = (b6 * b6) >>> 12;
         x1 = (b2 * sq) >>> 11;
         x2 = (ac2 * b6) >>> 11;
         x3 = x1 + x2;
         b3 = (((ac1 * 4 + x3) << oss) + 2) >>> 2;
         x1 = (ac3 * b6) >>> 13;
         x2 = (b1 * sq) >>> 16;
         x3 = (x1 + x2 + 2) >>> 2;
         b4 = (ac4 * $unsigned(x3 + 32768)) >> 15;
         b7 = (rawu - $unsigned(b3)) * (32'd50000 >> oss);
         if (b4 == 0) begin
            res.div_error = 1'b1;
         end else begin
            // keep the doubled quotient inside 32 bits
            if (b7 < 32'h8000_0000) q = (b7 * 2) / b4;
            else q = (b7 / b4) * 2;
            p  = int'(q);
            h  = p >>> 8;
            x1 = h * h;
            x1 = (x1 * 3038) >>> 16;
            x2 = (-7357 * p) >>> 16;
            res.value = p + ((x1 + x2 + 3791) >>> 4);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      bscu_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_payload.value, 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.kind !== want.kind)
               report_mismatch("kind", {31'd0, rsp_payload.kind}, {31'd0, want.kind});
            if (rsp_payload.value !== want.value)
               report_mismatch("value", rsp_payload.value, want.value);
            if (rsp_payload.div_error !== want.div_error)
               report_mismatch("div_error", {31'd0, rsp_payload.div_error},
                               {31'd0, want.div_error});
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_reading(input logic op, input logic [18:0] raw);
      bscu_pkg::req_type item;
      item.operation = op;
      item.raw_value = raw;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(compensate(item));
      @(negedge clock);
   endtask

   // wait until every response is back, then let the engine settle
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         bscu_pkg::REG_COEF_A: cal_a   = data[47:0];
         bscu_pkg::REG_COEF_U: cal_u   = data[47:0];
         bscu_pkg::REG_COEF_B: cal_b   = data[31:0];
         bscu_pkg::REG_COEF_M: cal_m   = data[31:0];
         bscu_pkg::REG_OSS:    cal_oss = data[1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic load_calibration(input logic [47:0] a, input logic [47:0] u,
                                   input logic [31:0] b, input logic [31:0] m,
                                   input logic [1:0] oss);
      csr_write(bscu_pkg::REG_COEF_A, {16'd0, a});
      csr_write(bscu_pkg::REG_COEF_U, {16'd0, u});
      csr_write(bscu_pkg::REG_COEF_B, {32'd0, b});
      csr_write(bscu_pkg::REG_COEF_M, {32'd0, m});
      csr_write(bscu_pkg::REG_OSS, {62'd0, oss});
   endtask

   // the classic example calibration
   task automatic load_typical(input logic [1:0] oss);
      load_calibration({16'sd408, -16'sd72, -16'sd14383},
                       {16'd32741, 16'd32757, 16'd23153},
                       {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868}, oss);
   endtask

   // all coefficients zero after reset: both divisors are zero
   task automatic test_reset_state;
      send_reading(bscu_pkg::OP_PRES, 19'd23843);
      send_reading(bscu_pkg::OP_TEMP, 19'd27898);
      send_reading(bscu_pkg::OP_PRES, 19'h7FFFF);
      drain();
   endtask

   task automatic test_typical_calibration;
      load_typical(2'd0);
      send_reading(bscu_pkg::OP_TEMP, 19'd27898);
      send_reading(bscu_pkg::OP_PRES, 19'd23843);
      // only the low 16 bits count for temperature
      send_reading(bscu_pkg::OP_TEMP, 19'h70000 | 19'd27898);
      send_reading(bscu_pkg::OP_TEMP, 19'd0);
      send_reading(bscu_pkg::OP_TEMP, 19'h7FFFF);
      send_reading(bscu_pkg::OP_PRES, 19'd0);
      send_reading(bscu_pkg::OP_PRES, 19'h7FFFF);
      drain();
      for (int o = 1; o <= 3; o++) begin
         csr_write(bscu_pkg::REG_OSS, 64'(o));
         send_reading(bscu_pkg::OP_TEMP, 19'd27898);
         send_reading(bscu_pkg::OP_PRES, 19'(23843 << o));
         drain();
      end
   endtask

   task automatic test_zero_divisor;
      // ac5 zero and md zero: temperature divisor is zero, b5 kept
      load_typical(2'd1);
      send_reading(bscu_pkg::OP_TEMP, 19'd30000);
      drain();
      csr_write(bscu_pkg::REG_COEF_U, {16'd0, 16'd32741, 16'd0, 16'd23153});
      csr_write(bscu_pkg::REG_COEF_M, {32'd0, -16'sd8711, 16'd0});
      send_reading(bscu_pkg::OP_TEMP, 19'd27898);
      send_reading(bscu_pkg::OP_PRES, 19'd40000);
      drain();
      // ac4 zero: pressure divisor is zero
      csr_write(bscu_pkg::REG_COEF_U, {16'd0, 16'd0, 16'd32757, 16'd23153});
      send_reading(bscu_pkg::OP_PRES, 19'd40000);
      drain();
   endtask

   task automatic test_extreme_calibration;
      load_calibration('1, '1, '1, '1, 2'd3);
      send_reading(bscu_pkg::OP_TEMP, 19'h0FFFF);
      send_reading(bscu_pkg::OP_PRES, 19'h7FFFF);
      send_reading(bscu_pkg::OP_TEMP, 19'd0);
      send_reading(bscu_pkg::OP_PRES, 19'd0);
      drain();
      load_calibration({16'h7FFF, 16'h8000, 16'h7FFF}, {16'hFFFF, 16'h8000, 16'h0000},
                       {16'h8000, 16'h7FFF}, {16'h7FFF, 16'h8000}, 2'd0);
      send_reading(bscu_pkg::OP_TEMP, 19'h0FFFF);
      send_reading(bscu_pkg::OP_PRES, 19'h7FFFF);
      send_reading(bscu_pkg::OP_TEMP, 19'h00001);
      send_reading(bscu_pkg::OP_PRES, 19'h00001);
      drain();
   endtask

   function automatic logic [15:0] jitter(input logic [15:0] base, input int span);
      return base + 16'($urandom_range(2 * span) - span);
   endfunction

   task automatic randomize_calibration;
      int mode;
      mode = $urandom_range(9);
      if (mode < 5) begin
         // near the typical calibration
         load_calibration({jitter(16'd408, 300), jitter(-16'sd72, 200),
                           jitter(-16'sd14383, 2000)},
                          {jitter(16'd32741, 4000), jitter(16'd32757, 4000),
                           jitter(16'd23153, 4000)},
                          {jitter(16'd6190, 1000), jitter(16'd4, 50)},
                          {jitter(-16'sd8711, 2000), jitter(16'd2868, 600)},
                          2'($urandom_range(3)));
      end else if (mode < 9) begin
         load_calibration(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                          $urandom, $urandom, 2'($urandom_range(3)));
      end else begin
         load_calibration($urandom_range(1) ? '1 : '0, $urandom_range(1) ? '1 : '0,
                          $urandom_range(1) ? '1 : '0, $urandom_range(1) ? '1 : '0,
                          2'($urandom_range(3)));
      end
   endtask

   // one phase of random readings under fresh calibrations
   task automatic test_random_phase(input int idle, input int stall, input int items);
      int         sent;
      logic [18:0] raw;
      idle_pct  = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < items) begin
         randomize_calibration();
         for (int k = 0; k < 60 && sent < items; k++) begin
            if ($urandom_range(3) == 0) raw = 19'($urandom);
            else raw = 19'($urandom_range(60000, 10000));
            // temperature first most of the time, then pressure
            if ($urandom_range(2) != 0) begin
               send_reading(bscu_pkg::OP_TEMP, raw);
               sent++;
            end
            if ($urandom_range(4) == 0) raw = 19'($urandom);
            else raw = 19'($urandom_range(90000, 15000) << cal_oss) >> 2;
            send_reading(bscu_pkg::OP_PRES, raw);
            sent++;
            // one full pause by the sender
            if (k == 20 && $urandom_range(1) == 0) begin
               req_valid <= 1'b0;
               while (pending_results.size() != 0) @(posedge clock);
               @(negedge clock);
            end
         end
         drain();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cal_a       = '0;
      cal_u       = '0;
      cal_b       = '0;
      cal_m       = '0;
      cal_oss     = bscu_pkg::OSS_RESET;
      held_b5     = 0;
      error_count = 0;
      idle_pct    = 0;
      stall_pct   = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_state();
      test_typical_calibration();
      test_zero_divisor();
      test_extreme_calibration();
      test_random_phase(0, 0, 480);
      test_random_phase(46, 0, 470);
      test_random_phase(0, 46, 470);
      test_random_phase(16, 16, 470);

      if (error_count == 0) begin
         $display("[baro_sensor_compensation_unit] OK");
      end else begin
         $display("[baro_sensor_compensation_unit] ERROR");
      end
      $finish;
   end
endmodule
